// File: hdl/ssp_pkg.sv
// ssp_pkg: word types, phase and status codes, and character helpers for
// the size string parser. No dependencies; used by ssp_step and size_string_parser.

package ssp_pkg;

  localparam int unsigned ValueW = 63;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned StatusW = 2;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_INIT   = 4'd0;
  localparam logic [PhaseW-1:0] PH_NUM    = 4'd1;
  localparam logic [PhaseW-1:0] PH_SUFFIX = 4'd2;
  localparam logic [PhaseW-1:0] PH_B      = 4'd5;
  localparam logic [PhaseW-1:0] PH_BY     = 4'd6;
  localparam logic [PhaseW-1:0] PH_BYT    = 4'd7;
  localparam logic [PhaseW-1:0] PH_BYTE   = 4'd8;
  localparam logic [PhaseW-1:0] PH_BYTES  = 4'd9;
  localparam logic [PhaseW-1:0] PH_ERR    = 4'd10;

  // Result status codes
  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_MALFORMED = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [7:0] char_code;
    logic       char_present;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [ValueW-1:0]  size_value;
    logic [StatusW-1:0] parse_status;
  } out_word_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [ValueW-1:0] acc;
    logic              ovf;
  } parse_state_t;

  // Case-insensitive match against an upper-case letter
  function automatic logic letter_is(input logic [7:0] c, input logic [7:0] upper_ch);
    letter_is = (c == upper_ch) || (c == (upper_ch + CASE_OFS));
  endfunction

endpackage

// File: hdl/ssp_step.sv
// ssp_step: one character step of the parser (phase, accumulator, overflow)
// plus the end-of-string result. Combinational; depends on ssp_pkg.

module ssp_step (
  input  ssp_pkg::parse_state_t cur_state,
  input  ssp_pkg::in_word_t     in_word,
  output ssp_pkg::parse_state_t nxt_state,
  output ssp_pkg::out_word_t    result
);

  logic [7:0]                 c;
  logic                       is_digit;
  logic [ssp_pkg::ValueW+3:0] dec_sum;
  logic                       fin_ok;

  assign c        = in_word.char_code;
  assign is_digit = c inside {[ssp_pkg::CH_ZERO:ssp_pkg::CH_NINE]};

  // acc * 10 + digit, kept 4 bits wider to see overflow past 63 bits
  assign dec_sum = {1'b0, cur_state.acc, 3'b000} + {3'b000, cur_state.acc, 1'b0}
                 + {{ssp_pkg::ValueW{1'b0}}, c[3:0]};

  // Next state for one word
  always_comb begin
    nxt_state = cur_state;
    if (in_word.char_present && (c != ssp_pkg::CH_SPACE)) begin
      case (cur_state.phase)
        ssp_pkg::PH_INIT, ssp_pkg::PH_NUM: begin
          if (is_digit) begin
            nxt_state.acc   = dec_sum[ssp_pkg::ValueW-1:0];
            nxt_state.ovf   = cur_state.ovf
                              || (dec_sum[ssp_pkg::ValueW+3:ssp_pkg::ValueW] != 4'd0);
            nxt_state.phase = ssp_pkg::PH_NUM;
          end else if (cur_state.phase == ssp_pkg::PH_NUM
                       && ssp_pkg::letter_is(c, ssp_pkg::CH_K)) begin
            nxt_state.acc   = {cur_state.acc[52:0], 10'd0};
            nxt_state.ovf   = cur_state.ovf || (cur_state.acc[62:53] != '0);
            nxt_state.phase = ssp_pkg::PH_SUFFIX;
          end else if (cur_state.phase == ssp_pkg::PH_NUM
                       && ssp_pkg::letter_is(c, ssp_pkg::CH_M)) begin
            nxt_state.acc   = {cur_state.acc[42:0], 20'd0};
            nxt_state.ovf   = cur_state.ovf || (cur_state.acc[62:43] != '0);
            nxt_state.phase = ssp_pkg::PH_SUFFIX;
          end else if (cur_state.phase == ssp_pkg::PH_NUM
                       && ssp_pkg::letter_is(c, ssp_pkg::CH_G)) begin
            nxt_state.acc   = {cur_state.acc[32:0], 30'd0};
            nxt_state.ovf   = cur_state.ovf || (cur_state.acc[62:33] != '0);
            nxt_state.phase = ssp_pkg::PH_SUFFIX;
          end else begin
            nxt_state.phase = ssp_pkg::PH_ERR;
          end
        end
        ssp_pkg::PH_SUFFIX:
          nxt_state.phase = ssp_pkg::letter_is(c, ssp_pkg::CH_B) ? ssp_pkg::PH_B
                                                                 : ssp_pkg::PH_ERR;
        ssp_pkg::PH_B:
          nxt_state.phase = ssp_pkg::letter_is(c, ssp_pkg::CH_Y) ? ssp_pkg::PH_BY
                                                                 : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BY:
          nxt_state.phase = ssp_pkg::letter_is(c, ssp_pkg::CH_T) ? ssp_pkg::PH_BYT
                                                                 : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYT:
          nxt_state.phase = ssp_pkg::letter_is(c, ssp_pkg::CH_E) ? ssp_pkg::PH_BYTE
                                                                 : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYTE:
          nxt_state.phase = ssp_pkg::letter_is(c, ssp_pkg::CH_S) ? ssp_pkg::PH_BYTES
                                                                 : ssp_pkg::PH_ERR;
        default:
          nxt_state.phase = ssp_pkg::PH_ERR;
      endcase
    end
  end

  // End-of-string result from the updated state; malformed wins over overflow
  always_comb begin
    fin_ok = nxt_state.phase inside {ssp_pkg::PH_NUM, ssp_pkg::PH_SUFFIX, ssp_pkg::PH_B,
                                     ssp_pkg::PH_BYTE, ssp_pkg::PH_BYTES};
    if (!fin_ok) begin
      result.size_value   = '0;
      result.parse_status = ssp_pkg::ST_MALFORMED;
    end else if (nxt_state.ovf) begin
      result.size_value   = '0;
      result.parse_status = ssp_pkg::ST_OVERFLOW;
    end else begin
      result.size_value   = nxt_state.acc;
      result.parse_status = ssp_pkg::ST_OK;
    end
  end

endmodule

// File: hdl/size_string_parser.sv
// size_string_parser: top level. Input register, parser state, result register.
// Depends on ssp_pkg and ssp_step.
//
//   channel | ports                          | word type
//   --------+--------------------------------+---------------------
//   input   | in_valid, in_stall, in_word    | ssp_pkg::in_word_t
//   result  | out_valid, out_stall, out_word | ssp_pkg::out_word_t
//
// One character per cycle while no last word waits on a stalled result: a word is
// held in the input register, then the parser state and (on the last word) the result
// register update. out_valid is registered and rises once the held last word is processed.
// Reset (synchronous, rst_n low) empties both registers and clears the state.
// Only a last word waits on a stalled result; other words keep flowing.

module size_string_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ssp_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ssp_pkg::out_word_t out_word
);

  logic                  in_v_r, in_v_nxt;
  ssp_pkg::in_word_t     in_r;
  ssp_pkg::parse_state_t st_r, st_nxt;
  ssp_pkg::parse_state_t step_state;
  ssp_pkg::out_word_t    step_result;
  logic                  out_v_r, out_v_nxt;
  ssp_pkg::out_word_t    out_r;
  logic                  can_proc;

  // A held word proceeds unless it needs the result register and that is blocked
  assign can_proc = in_v_r && (!in_r.is_last || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !can_proc;
  assign in_v_nxt = in_stall ? 1'b1 : in_valid;

  ssp_step u_step (
    .cur_state (st_r),
    .in_word   (in_r),
    .nxt_state (step_state),
    .result    (step_result)
  );

  // Parser state returns to its initial value after each string
  always_comb begin
    st_nxt = st_r;
    if (can_proc) begin
      if (in_r.is_last) begin
        st_nxt.phase = ssp_pkg::PH_INIT;
        st_nxt.acc   = '0;
        st_nxt.ovf   = 1'b0;
      end else begin
        st_nxt = step_state;
      end
    end
  end

  // Result register valid
  always_comb begin
    if (can_proc && in_r.is_last) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
      st_r.phase  <= ssp_pkg::PH_INIT;
      st_r.acc    <= '0;
      st_r.ovf    <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      st_r    <= st_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_word;
    end
    if (can_proc && in_r.is_last) begin
      out_r <= step_result;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // A finished string leaves the parser back in its initial state
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    can_proc && in_r.is_last |=> st_r.phase == ssp_pkg::PH_INIT && st_r.acc == '0 && !st_r.ovf)
    else $error("parser state not cleared after last word");

  // A new result only appears after a last word was processed
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(can_proc && in_r.is_last))
    else $error("result raised without a last word");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.parse_status != ssp_pkg::ST_OK |-> out_r.size_value == '0)
    else $error("error result with nonzero value");

  // Words that give no result never wait
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !in_r.is_last |-> !in_stall)
    else $error("non-last word stalled");

  // Status is one of the defined codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> out_r.parse_status == ssp_pkg::ST_OK
             || out_r.parse_status == ssp_pkg::ST_MALFORMED
             || out_r.parse_status == ssp_pkg::ST_OVERFLOW)
    else $error("undefined status code");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: sends size strings one character word at a time into
// size_string_parser and checks every parsed size against an in-bench parser.
// Depends on ssp_pkg and the size_string_parser RTL.

module testbench;

  localparam logic [63:0] SIZE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_MODE = 284;
  localparam int HOLD_CYCLES = 300;

  // Scoreboard: tracks the parser state and the sizes still owed by the block
  class size_scoreboard;
    logic [ssp_pkg::PhaseW-1:0] phase;
    logic [63:0] acc;  // bit 63 stays zero
    bit ovf;
    ssp_pkg::out_word_t pending_sizes[$];
    int mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase = ssp_pkg::PH_INIT;
      acc = '0;
      ovf = 1'b0;
    endfunction

    function void scale_by(int unsigned bits);
      if (acc > (SIZE_MAX >> bits)) ovf = 1'b1;
      acc = (acc << bits) & SIZE_MAX;
    endfunction

    function void take_char(logic [7:0] c);
      logic [7:0] u;
      logic [63:0] d;
      u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - ssp_pkg::CASE_OFS : c;
      d = {56'd0, 8'(c - ssp_pkg::CH_ZERO)};
      if (c == ssp_pkg::CH_SPACE) return;
      case (phase)
        ssp_pkg::PH_INIT, ssp_pkg::PH_NUM: begin
          if (c >= ssp_pkg::CH_ZERO && c <= ssp_pkg::CH_NINE) begin
            if (acc > (SIZE_MAX - d) / 10) ovf = 1'b1;
            acc = (acc * 10 + d) & SIZE_MAX;
            phase = ssp_pkg::PH_NUM;
          end else if (phase == ssp_pkg::PH_NUM
                       && (u == ssp_pkg::CH_K || u == ssp_pkg::CH_M || u == ssp_pkg::CH_G)) begin
            scale_by(u == ssp_pkg::CH_K ? 10 : (u == ssp_pkg::CH_M ? 20 : 30));
            phase = ssp_pkg::PH_SUFFIX;
          end else begin
            phase = ssp_pkg::PH_ERR;
          end
        end
        ssp_pkg::PH_SUFFIX: phase = (u == ssp_pkg::CH_B) ? ssp_pkg::PH_B : ssp_pkg::PH_ERR;
        ssp_pkg::PH_B:      phase = (u == ssp_pkg::CH_Y) ? ssp_pkg::PH_BY : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BY:     phase = (u == ssp_pkg::CH_T) ? ssp_pkg::PH_BYT : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYT:    phase = (u == ssp_pkg::CH_E) ? ssp_pkg::PH_BYTE : ssp_pkg::PH_ERR;
        ssp_pkg::PH_BYTE:   phase = (u == ssp_pkg::CH_S) ? ssp_pkg::PH_BYTES : ssp_pkg::PH_ERR;
        default:            phase = ssp_pkg::PH_ERR;
      endcase
    endfunction

    // Accepted input word: advance the parser, queue a size on the last word
    function void note_word(ssp_pkg::in_word_t w);
      ssp_pkg::out_word_t r;
      if (w.char_present) take_char(w.char_code);
      if (w.is_last) begin
        if (!(phase inside {ssp_pkg::PH_NUM, ssp_pkg::PH_SUFFIX, ssp_pkg::PH_B,
                            ssp_pkg::PH_BYTE, ssp_pkg::PH_BYTES})) begin
          r.size_value = '0;
          r.parse_status = ssp_pkg::ST_MALFORMED;
        end else if (ovf) begin
          r.size_value = '0;
          r.parse_status = ssp_pkg::ST_OVERFLOW;
        end else begin
          r.size_value = acc[ssp_pkg::ValueW-1:0];
          r.parse_status = ssp_pkg::ST_OK;
        end
        pending_sizes.push_back(r);
        restart();
      end
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(ssp_pkg::out_word_t got);
      ssp_pkg::out_word_t want;
      if (pending_sizes.size() == 0) begin
        report($sformatf("unexpected result size=%0d status=%0d",
                         got.size_value, got.parse_status));
        return;
      end
      want = pending_sizes.pop_front();
      if (got.size_value !== want.size_value)
        report($sformatf("size got %0d want %0d", got.size_value, want.size_value));
      if (got.parse_status !== want.parse_status)
        report($sformatf("status got %0d want %0d", got.parse_status, want.parse_status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ssp_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ssp_pkg::out_word_t out_word;

  size_scoreboard sb;
  logic [7:0] text_q[$];
  string vmax_txt = "9223372036854775807";
  string tail_txt = "BYTES";
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit add_noise = 1'b0;

  size_string_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("cycle limit reached");
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_word(in_word);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // Offer one word, with a random gap first; returns at the accepting edge
  task automatic send_word(input ssp_pkg::in_word_t w);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_idle_word(input logic last);
    ssp_pkg::in_word_t w;
    w.char_code = 8'($urandom_range(255));
    w.char_present = 1'b0;
    w.is_last = last;
    send_word(w);
  endtask

  // Send text_q as one string, ended on its last char or by an end-only word
  task automatic send_string(input bit end_only);
    ssp_pkg::in_word_t w;
    if (text_q.size() == 0) end_only = 1'b1;
    foreach (text_q[i]) begin
      if (add_noise && $urandom_range(15) == 0) begin
        send_idle_word(1'b0);
        items_sent++;
      end
      if (add_noise && $urandom_range(9) == 0) begin
        w.char_code = ssp_pkg::CH_SPACE;
        w.char_present = 1'b1;
        w.is_last = 1'b0;
        send_word(w);
        items_sent++;
      end
      w.char_code = text_q[i];
      w.char_present = 1'b1;
      w.is_last = !end_only && (i == text_q.size() - 1);
      send_word(w);
      items_sent++;
    end
    if (end_only) begin
      send_idle_word(1'b1);
      items_sent++;
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic push_letter(input logic [7:0] ch);
    text_q.push_back($urandom_range(1) ? ch + ssp_pkg::CASE_OFS : ch);
  endtask

  task automatic push_digits(input int n);
    repeat (n) text_q.push_back(ssp_pkg::CH_ZERO + 8'($urandom_range(9)));
  endtask

  // Digit run, sometimes right at the 63-bit limit
  task automatic gen_number();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      for (int i = 0; i < 17; i++) text_q.push_back(vmax_txt[i]);
      case ($urandom_range(2))
        0: begin
          text_q.push_back(vmax_txt[17]);
          text_q.push_back(vmax_txt[18]);
        end
        1: begin
          text_q.push_back(ssp_pkg::CH_ZERO);
          text_q.push_back(ssp_pkg::CH_ZERO + 8'd8);
        end
        default: push_digits(2);
      endcase
    end else if (pick < 60) begin
      push_digits($urandom_range(1, 4));
    end else if (pick < 85) begin
      push_digits($urandom_range(5, 12));
    end else begin
      push_digits($urandom_range(13, 20));
    end
  endtask

  // Optional K/M/G, then a prefix of BYTES
  task automatic gen_suffix();
    int s, t;
    s = $urandom_range(3);
    if (s == 0) return;
    push_letter(s == 1 ? ssp_pkg::CH_K : (s == 2 ? ssp_pkg::CH_M : ssp_pkg::CH_G));
    t = $urandom_range(5);
    for (int i = 0; i < t; i++) push_letter(tail_txt[i]);
  endtask

  task automatic gen_broken();
    case ($urandom_range(5))
      0: ;  // empty string
      1: begin
        push_digits($urandom_range(1, 3));
        push_letter(ssp_pkg::CH_T);
        push_digits($urandom_range(0, 2));
      end
      2: begin
        text_q.push_back(8'($urandom_range(255)));
        push_digits($urandom_range(1, 3));
      end
      3: begin
        gen_number();
        gen_suffix();
        text_q.push_back(8'($urandom_range(255)));
      end
      4: repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(255)));
      default: begin
        push_digits($urandom_range(1, 3));
        push_letter(ssp_pkg::CH_K);
        push_letter(8'h41 + 8'($urandom_range(25)));
      end
    endcase
  endtask

  task automatic random_string();
    text_q.delete();
    if ($urandom_range(99) < 75) begin
      gen_number();
      gen_suffix();
    end else begin
      gen_broken();
    end
    send_string($urandom_range(3) == 0);
  endtask

  task automatic directed_string(input string s, input bit end_only);
    text_q.delete();
    push_text(s);
    send_string(end_only);
  endtask

  initial begin
    int target;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle word, empty, zero, spaces, bad T suffix, partial suffixes
    send_idle_word(1'b0);
    directed_string("", 1'b1);
    directed_string("0", 1'b0);
    directed_string(" 3 k", 1'b0);
    directed_string("1T5", 1'b0);
    directed_string("2gBy", 1'b0);
    directed_string("8MBYTE", 1'b0);
    directed_string("4gbyt", 1'b1);

    // Random: three idle patterns, long result hold-off in the last
    add_noise = 1'b1;
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_left = HOLD_CYCLES;
        end
      endcase
      target = items_sent + ITEMS_PER_MODE;
      while (items_sent < target) random_string();
    end
    in_valid <= 1'b0;

    // Drain
    @(posedge clk);
    while (sb.pending_sizes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ssp_pkg.sv
hdl/ssp_step.sv
hdl/size_string_parser.sv
tb/sv/testbench.sv
